// ===== hdl/u8u16_pkg.sv =====
// shared types and constants for the utf-8 to utf-16 converter
package u8u16_pkg;

    localparam logic [15:0] REPLACEMENT  = 16'hFFFD;
    localparam logic [15:0] SURR_HI_BASE = 16'hD800;
    localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;
    localparam int          MAX_UNITS    = 3;
    localparam int          HOLD_DEPTH   = 3;

    // one input item
    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
    } u8u16_in_t;

    // one result item
    typedef struct packed {
        logic [15:0] code_unit;
        logic        run_last;
        logic        text_last;
    } u8u16_out_t;

    // all units that one input item causes, first unit at index 0
    typedef struct packed {
        logic [MAX_UNITS-1:0][15:0] units;
        logic [1:0]                 count;
        logic                       text_end;
    } u8u16_bundle_t;

endpackage

// ===== hdl/u8u16_in_reg.sv =====
// input register stage of the converter
module u8u16_in_reg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  u8u16_pkg::u8u16_in_t  s_data,
    input  logic                  advance,
    output logic                  item_valid,
    output u8u16_pkg::u8u16_in_t  item
);
    import u8u16_pkg::*;

    logic      valid_reg;
    u8u16_in_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

endmodule

// ===== hdl/u8u16_decode.sv =====
// sequence hold and combinational decode of one byte into its units
module u8u16_decode (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  u8u16_pkg::u8u16_in_t      item,
    input  logic                      advance,
    output u8u16_pkg::u8u16_bundle_t  bundle
);
    import u8u16_pkg::*;

    logic [7:0] held_reg [HOLD_DEPTH];
    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;

    logic [7:0]  b0, b1, b2, b3;
    logic [2:0]  n;
    logic [2:0]  len0;
    logic        complete;
    logic        hold_wr;
    logic [20:0] cp;
    logic [20:0] v;

    // sequence length from the lead byte, 1 for ascii and bad leads
    function automatic logic [2:0] seq_len(input logic [7:0] c);
        logic [2:0] r;
        if (!c[7]) begin
            r = 3'd1;
        end else if (c[7:5] == 3'b110) begin
            r = 3'd2;
        end else if (c[7:4] == 4'b1110) begin
            r = 3'd3;
        end else if (c[7:3] == 5'b11110) begin
            r = 3'd4;
        end else begin
            r = 3'd1;
        end
        return r;
    endfunction

    // a byte decoded on its own
    function automatic logic [15:0] single(input logic [7:0] c);
        return c[7] ? REPLACEMENT : {8'h00, c};
    endfunction

    // assemble the byte window: held bytes, then the new byte
    always_comb begin
        b0 = (held_count_reg > 2'd0) ? held_reg[0] : item.in_byte;
        b1 = (held_count_reg > 2'd1) ? held_reg[1] : item.in_byte;
        b2 = (held_count_reg > 2'd2) ? held_reg[2] : item.in_byte;
        b3 = item.in_byte;
    end

    assign n        = {1'b0, held_count_reg} + 3'd1;
    assign len0     = seq_len(b0);
    assign complete = (n >= len0);

    always_comb begin
        case (len0)
            3'd2:    cp = {10'b0, b0[4:0], b1[5:0]};
            3'd3:    cp = {5'b0, b0[3:0], b1[5:0], b2[5:0]};
            3'd4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            default: cp = {5'b0, single(b0)};
        endcase
    end

    assign v = cp - SUPP_BASE;

    always_comb begin
        bundle          = '0;
        bundle.text_end = item.string_end;
        hold_wr         = 1'b0;
        if (complete) begin
            if (cp[20:16] != 5'b0) begin
                bundle.units[0] = {5'b0, v[20:10]} + SURR_HI_BASE;
                bundle.units[1] = {6'b0, v[9:0]} + SURR_LO_BASE;
                bundle.count    = 2'd2;
            end else begin
                bundle.units[0] = cp[15:0];
                bundle.count    = 2'd1;
            end
        end else if (item.string_end) begin
            // cut-off lead gives a replacement, the rest decodes again
            bundle.units[0] = REPLACEMENT;
            case (held_count_reg)
                2'd1: begin
                    bundle.units[1] = single(b1);
                    bundle.count    = 2'd2;
                end
                2'd2: begin
                    if (seq_len(b1) == 3'd2) begin
                        bundle.units[1] = {5'b0, b1[4:0], b2[5:0]};
                        bundle.count    = 2'd2;
                    end else begin
                        bundle.units[1] = single(b1);
                        bundle.units[2] = single(b2);
                        bundle.count    = 2'd3;
                    end
                end
                default: begin
                    bundle.count = 2'd1;
                end
            endcase
        end else begin
            hold_wr = 1'b1;
        end
    end

    assign held_count_next = hold_wr ? n[1:0] : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg <= 2'd0;
        end else if (advance) begin
            held_count_reg <= held_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && hold_wr) begin
            held_reg[held_count_reg] <= item.in_byte;
        end
    end

endmodule

// ===== hdl/u8u16_out_stage.sv =====
// result register and unit serializer
module u8u16_out_stage (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load,
    input  u8u16_pkg::u8u16_bundle_t  bundle,
    output logic                      can_load,
    output logic                      m_valid,
    input  logic                      m_ready,
    output u8u16_pkg::u8u16_out_t     m_data
);
    import u8u16_pkg::*;

    u8u16_bundle_t bundle_reg;
    logic          valid_reg;
    logic [1:0]    idx_reg;
    logic [1:0]    idx_next;
    logic          last;

    assign last     = (idx_reg == bundle_reg.count - 2'd1);
    assign can_load = !valid_reg || (m_ready && last);
    assign m_valid  = valid_reg;

    always_comb begin
        m_data.code_unit = bundle_reg.units[idx_reg];
        m_data.run_last  = last;
        m_data.text_last = last && bundle_reg.text_end;
    end

    always_comb begin
        idx_next = idx_reg;
        if (load) begin
            idx_next = 2'd0;
        end else if (valid_reg && m_ready && !last) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            idx_reg <= idx_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (valid_reg && m_ready && last) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bundle_reg <= bundle;
        end
    end

endmodule

// ===== hdl/utf8_to_utf16le_converter_top.sv =====
// top level of the utf-8 to utf-16 converter
//
//  channel | direction | handshake          | item
//  s_      | in        | s_valid / s_ready  | u8u16_in_t  (in_byte, string_end)
//  m_      | out       | m_valid / m_ready  | u8u16_out_t (code_unit, run_last, text_last)
//
// one byte is taken per cycle while each byte gives at most one unit and m_ready does not stall
// a byte that gives k units (k up to 3) holds the result register until all k are sent,
// since the serializer sends one unit per cycle while m_ready is high
// first unit of a byte passes the input register, then the result register, before m_ offers it
// aresetn (synchronous, active low) empties both registers and the hold
// a stall on m_ready backs up into s_ready once the input register is full
module utf8_to_utf16le_converter_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  u8u16_pkg::u8u16_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output u8u16_pkg::u8u16_out_t m_data
);
    import u8u16_pkg::*;

    logic          item_valid;
    u8u16_in_t     item;
    u8u16_bundle_t bundle;
    logic          can_load;
    logic          advance;
    logic          load;

    // an item that leaves no unit only updates the hold, so it never waits
    assign advance = item_valid && ((bundle.count == 2'd0) || can_load);
    // only items with units land in the result register
    assign load    = advance && (bundle.count != 2'd0);

    // input register
    u8u16_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // partial sequence hold and decode
    u8u16_decode u_dec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item),
        .advance (advance),
        .bundle  (bundle)
    );

    // result register, one unit per cycle out while m_ready is high
    u8u16_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .bundle   (bundle),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ===== hdl/u8u16_checker.sv =====
// port-level checks for the converter top level, with bind
module u8u16_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input u8u16_pkg::u8u16_in_t  s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input u8u16_pkg::u8u16_out_t m_data
);
    import u8u16_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // string end only on the last unit of an item
    a_text_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.text_last |-> m_data.run_last)
        else $error("text_last without run_last");

    // remaining units of an item follow without a gap
    a_run_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.run_last |=> m_valid)
        else $error("gap inside the units of one item");

    // with nothing waiting at the output the input side is open
    a_in_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked while output empty");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind utf8_to_utf16le_converter_top u8u16_checker u_chk (.*);

// ===== verif/u8u16_stream_checker.sv =====
// channel monitor, expected code unit predictor and comparator for the utf-8 to utf-16 converter
module u8u16_stream_checker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  u8u16_pkg::u8u16_in_t  s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  u8u16_pkg::u8u16_out_t m_data,
    output int unsigned           error_count,
    output int unsigned           units_owed,
    output int unsigned           units_checked
);
    import u8u16_pkg::*;

    logic [HOLD_DEPTH-1:0][7:0] held_octets;
    int unsigned                held_count;
    logic [15:0]                step_units [$];
    u8u16_out_t                 owed_units [$];
    int unsigned                errors;
    int unsigned                checked;

    initial begin
        errors        = 0;
        checked       = 0;
        held_count    = 0;
        held_octets   = '0;
    end

    // sequence length from the lead byte, 1 for ascii and bad leads
    function automatic int unsigned lead_length(logic [7:0] lead);
        if (lead < 8'h80) return 1;
        if (lead[7:5] == 3'b110) return 2;
        if (lead[7:4] == 4'b1110) return 3;
        if (lead[7:3] == 5'b11110) return 4;
        return 1;
    endfunction

    // followers are masked, never checked
    function automatic logic [20:0] join_sequence(logic [3:0][7:0] octets, int unsigned at,
                                                  int unsigned len);
        logic [3:0][7:0] s;
        s = octets >> (8 * at);
        case (len)
            2: return {10'd0, s[0][4:0], s[1][5:0]};
            3: return {5'd0, s[0][3:0], s[1][5:0], s[2][5:0]};
            4: return {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
            default: return (s[0] < 8'h80) ? {13'd0, s[0]} : {5'd0, REPLACEMENT};
        endcase
    endfunction

    task automatic add_unit(logic [15:0] unit_value);
        if (step_units.size() < MAX_UNITS) step_units = {step_units, unit_value};
    endtask

    task automatic add_code_point(logic [20:0] cp);
        logic [20:0] v;
        if (cp <= 21'h00FFFF) begin
            add_unit(cp[15:0]);
        end else begin
            v = cp - SUPP_BASE;
            add_unit(16'(v >> 10) + SURR_HI_BASE);
            add_unit(16'(v[9:0]) + SURR_LO_BASE);
        end
    endtask

    task automatic predict_units(u8u16_in_t item);
        logic [3:0][7:0] octets;
        int unsigned     n;
        int unsigned     i;
        int unsigned     len;
        u8u16_out_t      unit_item;
        step_units.delete();
        octets = '0;
        n = 0;
        for (i = 0; i < held_count; i++) begin
            octets[n] = held_octets[i];
            n++;
        end
        octets[n] = item.in_byte;
        n++;
        if (item.string_end) begin
            // flush: lead bytes short of followers give the replacement unit
            i = 0;
            while (i < n) begin
                len = lead_length(octets[i]);
                if (i + len <= n) begin
                    add_code_point(join_sequence(octets, i, len));
                    i += len;
                end else begin
                    add_unit(REPLACEMENT);
                    i++;
                end
            end
            held_count = 0;
        end else begin
            len = lead_length(octets[0]);
            if (n >= len) begin
                add_code_point(join_sequence(octets, 0, len));
                held_count = 0;
            end else begin
                for (i = 0; i < n; i++) held_octets[i] = octets[i];
                held_count = n;
            end
        end
        foreach (step_units[k]) begin
            unit_item.code_unit = step_units[k];
            unit_item.run_last  = (k == step_units.size() - 1);
            unit_item.text_last = unit_item.run_last && item.string_end;
            owed_units = {owed_units, unit_item};
        end
    endtask

    task automatic check_unit(u8u16_out_t got);
        u8u16_out_t want;
        if (owed_units.size() == 0) begin
            $display("%0t: unexpected unit, got code_unit %h run_last %b text_last %b",
                     $time, got.code_unit, got.run_last, got.text_last);
            errors++;
        end else begin
            want = owed_units.pop_front();
            if (got.code_unit !== want.code_unit || got.run_last !== want.run_last ||
                    got.text_last !== want.text_last) begin
                $display("%0t: mismatch, expected %h/%b/%b got %h/%b/%b", $time,
                         want.code_unit, want.run_last, want.text_last,
                         got.code_unit, got.run_last, got.text_last);
                errors++;
            end
            checked++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            held_count = 0;
            owed_units.delete();
        end else begin
            if (s_valid && s_ready) predict_units(s_data);
            if (m_valid && m_ready) check_unit(m_data);
        end
        error_count   <= errors;
        units_owed    <= owed_units.size();
        units_checked <= checked;
    end

endmodule

// ===== verif/utf8_to_utf16le_converter_top_test.sv =====
// stimulus, clock, reset and verdict for the utf-8 to utf-16 converter
module utf8_to_utf16le_converter_top_test;
    import u8u16_pkg::*;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    u8u16_in_t   s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    u8u16_out_t  m_data;

    int unsigned error_count;
    int unsigned units_owed;
    int unsigned units_checked;

    // chance in percent that the sender idles / the receiver stalls in a given cycle
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int unsigned bytes_sent = 0;
    int unsigned strings_sent = 0;

    // opening items: bit 8 marks the final byte of a string
    logic [8:0] opening [25] = '{
        9'h000, 9'h07F,                     // ascii extremes
        9'h080, 9'h0FF, 9'h1F8,             // lone continuation, bad leads, string end
        9'h0C0, 9'h080,                     // overlong two byte form
        9'h0ED, 9'h0A0, 9'h080,             // surrogate code point passes through
        9'h0F0, 9'h09F, 9'h098, 9'h080,     // surrogate pair
        9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,     // largest four byte form at string end
        9'h0F0, 9'h09F, 9'h141,             // string ends inside a sequence: three units
        9'h0E2, 9'h1FF,                     // cut three byte form, bad follower
        9'h0C2, 9'h1A9                      // plain two byte form
    };

    utf8_to_utf16le_converter_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    u8u16_stream_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .error_count   (error_count),
        .units_owed    (units_owed),
        .units_checked (units_checked)
    );

    always #6 aclk = ~aclk;

    // receiver: fresh stall decision every cycle
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // one item; an optional idle gap comes before it so valid never drops mid-item
    task automatic send_byte(input logic [7:0] value, input logic last);
        int unsigned gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < idle_pct) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{in_byte: value, string_end: last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    function automatic logic [7:0] lead_byte(int unsigned len);
        case (len)
            2: return {3'b110, 5'($urandom_range(0, 31))};
            3: return {4'b1110, 4'($urandom_range(0, 15))};
            4: return {5'b11110, 3'($urandom_range(0, 7))};
            default: return 8'($urandom_range(0, 127));
        endcase
    endfunction

    // mostly proper followers, now and then any byte since the decoder is lax
    function automatic logic [7:0] follower_byte();
        if ($urandom_range(0, 5) == 0) return 8'($urandom_range(0, 255));
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    // a string of a few characters, mostly well formed, some noise and cut sequences
    task automatic send_random_string(output int unsigned count);
        logic [7:0]  text [$];
        int unsigned chars;
        int unsigned kind;
        int unsigned len;
        int unsigned keep;
        int unsigned c;
        int unsigned k;
        chars = $urandom_range(1, 5);
        for (c = 0; c < chars; c++) begin
            kind = $urandom_range(0, 9);
            if (kind < 9) begin
                len = (kind < 3) ? 1 : (kind < 5) ? 2 : (kind < 7) ? 3 : 4;
                text = {text, lead_byte(len)};
                for (k = 1; k < len; k++) text = {text, follower_byte()};
            end else if ($urandom_range(0, 1) == 0) begin
                // noise byte of any value
                text = {text, 8'($urandom_range(0, 255))};
            end else begin
                // lead with too few followers
                len  = $urandom_range(2, 4);
                keep = $urandom_range(0, len - 2);
                text = {text, lead_byte(len)};
                for (k = 0; k < keep; k++) text = {text, follower_byte()};
            end
        end
        foreach (text[i]) send_byte(text[i], i == text.size() - 1);
        count = text.size();
        strings_sent++;
    endtask

    initial begin
        int unsigned phase;
        int unsigned in_phase;
        int unsigned count;

        // hold reset, then release once
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed items with no idling on either side
        foreach (opening[i]) send_byte(opening[i][7:0], opening[i][8]);

        // random strings across the idling phases
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 80; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 80; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            in_phase = 0;
            while (in_phase < 18) begin
                send_random_string(count);
                in_phase += count;
            end
        end
        s_valid <= 1'b0;

        // drain: wait until every owed unit is seen, then let the clock run on before the verdict
        do @(posedge aclk); while (units_owed != 0);
        repeat (8) @(posedge aclk);

        $display("sent %0d bytes in %0d random strings plus directed items, checked %0d units",
                 bytes_sent, strings_sent, units_checked);
        $display("idling phases covered: none, sender 80%%, receiver 80%%, both 18%%");
        if (error_count == 0 && units_owed == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog for a hung handshake
    initial begin
        #(12 * 400000);
        $display("FAIL");
        $finish;
    end

endmodule
